/* sv/vvcab_pkg.sv */
// shared types and codes for the vvc rtp to annex-b depacketizer
`default_nettype none

package vvcab_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] seq_t;
    typedef logic [15:0] unit_len_t;

    // nal unit types carried in the payload header
    localparam logic [4:0] NAL_TYPE_AP       = 5'd28;
    localparam logic [4:0] NAL_TYPE_FU       = 5'd29;
    localparam logic [4:0] NAL_TYPE_LONG_LO  = 5'd13;
    localparam logic [4:0] NAL_TYPE_LONG_HI  = 5'd18;

    // packet kind codes
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_AGGR   = 2'd2;
    localparam logic [1:0] KIND_FRAG   = 2'd3;

    // aggregation unit phases
    localparam logic [2:0] PH_SIZE_HI = 3'd0;
    localparam logic [2:0] PH_SIZE_LO = 3'd1;
    localparam logic [2:0] PH_HDR0    = 3'd2;
    localparam logic [2:0] PH_HDR1    = 3'd3;
    localparam logic [2:0] PH_BODY    = 3'd4;

    // saturating byte position within a packet
    localparam logic [1:0] POS_IDLE  = 2'd0;
    localparam logic [1:0] POS_HDR1  = 2'd1;
    localparam logic [1:0] POS_FUHDR = 2'd2;
    localparam logic [1:0] POS_BODY  = 2'd3;

    // result slots, emitted lowest index first
    localparam int NUM_SLOTS     = 8;
    localparam int SLOT_PRE_DROP = 0;
    localparam int SLOT_ZERO_X   = 1;
    localparam int SLOT_ZERO_A   = 2;
    localparam int SLOT_ZERO_B   = 3;
    localparam int SLOT_ONE      = 4;
    localparam int SLOT_HDR      = 5;
    localparam int SLOT_DATA     = 6;
    localparam int SLOT_MARK     = 7;

    localparam byte_t START_ZERO = 8'h00;
    localparam byte_t START_ONE  = 8'h01;

    function automatic logic long_start(input logic [4:0] nal_type);
        return (nal_type >= NAL_TYPE_LONG_LO) && (nal_type <= NAL_TYPE_LONG_HI);
    endfunction

endpackage

`default_nettype wire

/* sv/vvc_rtp_to_annexb_unit.sv */
// vvc rtp payload to annex-b byte stream converter
//
//  channel | dir | ports                                              | transfer
//  --------+-----+----------------------------------------------------+--------------------
//  s_      | in  | payload_byte, first_of_packet, last_of_packet, seq | s_valid & s_ready
//  m_      | out | out_byte, byte_valid, end_of_nal, nal_dropped      | m_valid & m_ready
//
//  an input byte is registered, then decoded combinationally into up to seven results
//  held in an eight-slot result register that drains one result per cycle
//  while m_ready is high; the next item loads only when at most one result is left
//  and it is being taken, so multi-result items (start codes, marker pairs) hold s_ready
//  aresetn is synchronous, active low, and clears all packet state
//  a stall on m_ready backs up through the result register to s_ready
`default_nettype none

module vvc_rtp_to_annexb_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire vvcab_pkg::byte_t  s_payload_byte,
    input  wire logic              s_first_of_packet,
    input  wire logic              s_last_of_packet,
    input  wire vvcab_pkg::seq_t   s_seq_number,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output vvcab_pkg::byte_t       m_out_byte,
    output logic                   m_byte_valid,
    output logic                   m_end_of_nal,
    output logic                   m_nal_dropped
);
    import vvcab_pkg::*;

    // input register
    logic      in_valid_reg;
    byte_t     in_byte_reg;
    logic      in_first_reg;
    logic      in_last_reg;
    seq_t      in_seq_reg;

    // packet state
    seq_t      last_seq_reg,       last_seq_next;
    logic [1:0] byte_pos_reg,      byte_pos_next;
    logic [1:0] packet_kind_reg,   packet_kind_next;
    logic      packet_skipped_reg, packet_skipped_next;
    byte_t     held_header_reg,    held_header_next;
    logic [2:0] held_second_reg,   held_second_next;
    logic      frag_open_reg,      frag_open_next;
    logic      frag_end_seen_reg,  frag_end_seen_next;
    unit_len_t unit_remaining_reg, unit_remaining_next;
    logic [2:0] unit_phase_reg,    unit_phase_next;

    // result register: one presence bit per slot plus the variable fields
    logic [NUM_SLOTS-1:0] slot_mask_reg, slot_mask_next;
    byte_t     hdr_byte_reg,  hdr_byte_next;
    byte_t     data_byte_reg, data_byte_next;
    logic      data_end_reg,  data_end_next;
    logic      mark_drop_reg, mark_drop_next;

    logic [NUM_SLOTS-1:0] slot_rest;
    logic      load_ok;
    logic      consume;
    logic      pop;

    // handshake: a new item enters whenever the decoded one can move into the results
    assign slot_rest = slot_mask_reg & (slot_mask_reg - 1'b1);
    assign m_valid   = |slot_mask_reg;
    assign pop       = m_valid && m_ready;
    assign load_ok   = (slot_rest == '0) && (!m_valid || m_ready);
    assign consume   = in_valid_reg && load_ok;
    assign s_ready   = !in_valid_reg || consume;

    // decode of the registered item
    always_comb begin
        logic       active;
        logic [1:0] pos_cur;
        logic [4:0] nal_type;
        unit_len_t  rem_dec;

        last_seq_next       = last_seq_reg;
        byte_pos_next       = byte_pos_reg;
        packet_kind_next    = packet_kind_reg;
        packet_skipped_next = packet_skipped_reg;
        held_header_next    = held_header_reg;
        held_second_next    = held_second_reg;
        frag_open_next      = frag_open_reg;
        frag_end_seen_next  = frag_end_seen_reg;
        unit_remaining_next = unit_remaining_reg;
        unit_phase_next     = unit_phase_reg;

        slot_mask_next = '0;
        hdr_byte_next  = held_header_reg;
        data_byte_next = in_byte_reg;
        data_end_next  = 1'b0;
        mark_drop_next = 1'b0;

        active   = 1'b0;
        pos_cur  = byte_pos_reg;
        nal_type = in_byte_reg[7:3];
        rem_dec  = unit_remaining_reg - 1'b1;

        if (in_first_reg) begin
            active  = 1'b1;
            pos_cur = POS_IDLE;
            // previous packet cut short: close its nal unless a fragment run goes on
            if (byte_pos_reg != POS_IDLE && !packet_skipped_reg) begin
                priority if (packet_kind_reg == KIND_SINGLE) begin
                    slot_mask_next[SLOT_PRE_DROP] = 1'b1;
                end else if (packet_kind_reg == KIND_AGGR) begin
                    if (unit_phase_reg == PH_BODY) begin
                        slot_mask_next[SLOT_PRE_DROP] = 1'b1;
                    end
                end else if (packet_kind_reg == KIND_FRAG) begin
                    if (frag_open_reg && frag_end_seen_reg) begin
                        slot_mask_next[SLOT_PRE_DROP] = 1'b1;
                        frag_open_next = 1'b0;
                    end
                end else begin
                end
            end
            packet_kind_next    = KIND_NONE;
            frag_end_seen_next  = 1'b0;
            unit_phase_next     = PH_SIZE_HI;
            unit_remaining_next = '0;
            // late packets are ignored, no wrap handling
            if (in_seq_reg < last_seq_reg) begin
                packet_skipped_next = 1'b1;
            end else begin
                packet_skipped_next = 1'b0;
                last_seq_next       = in_seq_reg;
            end
        end else if (byte_pos_reg != POS_IDLE) begin
            active = 1'b1;
        end

        if (active) begin
            byte_pos_next = (pos_cur == POS_BODY) ? POS_BODY : pos_cur + 2'd1;

            if (!packet_skipped_next) begin
                priority if (pos_cur == POS_IDLE) begin
                    held_header_next = in_byte_reg;
                end else if (pos_cur == POS_HDR1) begin
                    held_second_next = in_byte_reg[2:0];
                    priority if (nal_type == NAL_TYPE_AP) begin
                        packet_kind_next = KIND_AGGR;
                        if (frag_open_reg) begin
                            slot_mask_next[SLOT_PRE_DROP] = 1'b1;
                            frag_open_next = 1'b0;
                        end
                    end else if (nal_type == NAL_TYPE_FU) begin
                        packet_kind_next = KIND_FRAG;
                    end else begin
                        packet_kind_next = KIND_SINGLE;
                        if (frag_open_reg) begin
                            slot_mask_next[SLOT_PRE_DROP] = 1'b1;
                            frag_open_next = 1'b0;
                        end
                        slot_mask_next[SLOT_ZERO_X] = long_start(nal_type);
                        slot_mask_next[SLOT_ZERO_A] = 1'b1;
                        slot_mask_next[SLOT_ZERO_B] = 1'b1;
                        slot_mask_next[SLOT_ONE]    = 1'b1;
                        slot_mask_next[SLOT_HDR]    = 1'b1;
                        slot_mask_next[SLOT_DATA]   = 1'b1;
                        data_end_next               = in_last_reg;
                    end
                end else if (packet_kind_reg == KIND_SINGLE) begin
                    slot_mask_next[SLOT_DATA] = 1'b1;
                    data_end_next             = in_last_reg;
                end else if (packet_kind_reg == KIND_AGGR) begin
                    unique case (unit_phase_reg)
                        PH_SIZE_HI: begin
                            unit_remaining_next = {in_byte_reg, 8'h00};
                            unit_phase_next     = PH_SIZE_LO;
                        end
                        PH_SIZE_LO: begin
                            unit_remaining_next = unit_remaining_reg | {8'h00, in_byte_reg};
                            unit_phase_next = (unit_remaining_next == '0) ? PH_SIZE_HI
                                                                          : PH_HDR0;
                        end
                        PH_HDR0: begin
                            held_header_next    = in_byte_reg;
                            unit_remaining_next = rem_dec;
                            unit_phase_next = (rem_dec == '0) ? PH_SIZE_HI : PH_HDR1;
                        end
                        PH_HDR1: begin
                            unit_remaining_next = rem_dec;
                            slot_mask_next[SLOT_ZERO_X] = long_start(nal_type);
                            slot_mask_next[SLOT_ZERO_A] = 1'b1;
                            slot_mask_next[SLOT_ZERO_B] = 1'b1;
                            slot_mask_next[SLOT_ONE]    = 1'b1;
                            slot_mask_next[SLOT_HDR]    = 1'b1;
                            slot_mask_next[SLOT_DATA]   = 1'b1;
                            data_end_next   = (rem_dec == '0);
                            unit_phase_next = (rem_dec == '0) ? PH_SIZE_HI : PH_BODY;
                        end
                        default: begin
                            unit_remaining_next       = rem_dec;
                            slot_mask_next[SLOT_DATA] = 1'b1;
                            data_end_next             = (rem_dec == '0);
                            if (rem_dec == '0) begin
                                unit_phase_next = PH_SIZE_HI;
                            end
                        end
                    endcase
                    // unit cut off by the end of the packet
                    if (in_last_reg && unit_phase_next == PH_BODY) begin
                        slot_mask_next[SLOT_MARK] = 1'b1;
                        mark_drop_next            = 1'b1;
                    end
                end else if (packet_kind_reg == KIND_FRAG) begin
                    if (pos_cur == POS_FUHDR) begin
                        // fu header: start, end, type
                        priority if (in_last_reg && !frag_open_reg && !in_byte_reg[7]) begin
                            packet_skipped_next = 1'b1;
                        end else if (in_byte_reg[7]) begin
                            if (frag_open_reg) begin
                                slot_mask_next[SLOT_PRE_DROP] = 1'b1;
                            end
                            slot_mask_next[SLOT_ZERO_A] = 1'b1;
                            slot_mask_next[SLOT_ZERO_B] = 1'b1;
                            slot_mask_next[SLOT_ONE]    = 1'b1;
                            slot_mask_next[SLOT_HDR]    = 1'b1;
                            slot_mask_next[SLOT_DATA]   = 1'b1;
                            data_byte_next = {in_byte_reg[4:0], held_second_reg};
                            data_end_next  = in_last_reg && in_byte_reg[6];
                            frag_end_seen_next = in_byte_reg[6];
                            frag_open_next     = !(in_last_reg && in_byte_reg[6]);
                        end else if (frag_open_reg) begin
                            frag_end_seen_next = in_byte_reg[6];
                            if (in_last_reg && in_byte_reg[6]) begin
                                // end fragment with no payload: bare end marker
                                slot_mask_next[SLOT_MARK] = 1'b1;
                                mark_drop_next            = 1'b0;
                                frag_open_next            = 1'b0;
                            end
                        end else begin
                            packet_skipped_next = 1'b1;
                        end
                    end else if (frag_open_reg) begin
                        slot_mask_next[SLOT_DATA] = 1'b1;
                        data_end_next = in_last_reg && frag_end_seen_reg;
                        if (in_last_reg && frag_end_seen_reg) begin
                            frag_open_next = 1'b0;
                        end
                    end
                end else begin
                end
            end

            if (in_last_reg) begin
                byte_pos_next       = POS_IDLE;
                packet_kind_next    = KIND_NONE;
                packet_skipped_next = 1'b0;
                frag_end_seen_next  = 1'b0;
                unit_phase_next     = PH_SIZE_HI;
                unit_remaining_next = '0;
            end
        end
    end

    // control and packet state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            slot_mask_reg      <= '0;
            last_seq_reg       <= '0;
            byte_pos_reg       <= POS_IDLE;
            packet_kind_reg    <= KIND_NONE;
            packet_skipped_reg <= 1'b0;
            held_header_reg    <= '0;
            held_second_reg    <= '0;
            frag_open_reg      <= 1'b0;
            frag_end_seen_reg  <= 1'b0;
            unit_remaining_reg <= '0;
            unit_phase_reg     <= PH_SIZE_HI;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (consume) begin
                slot_mask_reg      <= slot_mask_next;
                last_seq_reg       <= last_seq_next;
                byte_pos_reg       <= byte_pos_next;
                packet_kind_reg    <= packet_kind_next;
                packet_skipped_reg <= packet_skipped_next;
                held_header_reg    <= held_header_next;
                held_second_reg    <= held_second_next;
                frag_open_reg      <= frag_open_next;
                frag_end_seen_reg  <= frag_end_seen_next;
                unit_remaining_reg <= unit_remaining_next;
                unit_phase_reg     <= unit_phase_next;
            end else if (pop) begin
                slot_mask_reg <= slot_rest;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_payload_byte;
            in_first_reg <= s_first_of_packet;
            in_last_reg  <= s_last_of_packet;
            in_seq_reg   <= s_seq_number;
        end
        if (consume) begin
            hdr_byte_reg  <= hdr_byte_next;
            data_byte_reg <= data_byte_next;
            data_end_reg  <= data_end_next;
            mark_drop_reg <= mark_drop_next;
        end
    end

    // head of the result register: lowest pending slot goes out
    always_comb begin
        m_out_byte    = START_ZERO;
        m_byte_valid  = 1'b0;
        m_end_of_nal  = 1'b0;
        m_nal_dropped = 1'b0;
        priority if (slot_mask_reg[SLOT_PRE_DROP]) begin
            m_end_of_nal  = 1'b1;
            m_nal_dropped = 1'b1;
        end else if (slot_mask_reg[SLOT_ZERO_X] || slot_mask_reg[SLOT_ZERO_A]
                     || slot_mask_reg[SLOT_ZERO_B]) begin
            m_byte_valid = 1'b1;
        end else if (slot_mask_reg[SLOT_ONE]) begin
            m_out_byte   = START_ONE;
            m_byte_valid = 1'b1;
        end else if (slot_mask_reg[SLOT_HDR]) begin
            m_out_byte   = hdr_byte_reg;
            m_byte_valid = 1'b1;
        end else if (slot_mask_reg[SLOT_DATA]) begin
            m_out_byte   = data_byte_reg;
            m_byte_valid = 1'b1;
            m_end_of_nal = data_end_reg;
        end else if (slot_mask_reg[SLOT_MARK]) begin
            m_end_of_nal  = 1'b1;
            m_nal_dropped = mark_drop_reg;
        end else begin
        end
    end

    // a packet's last byte always leaves the block between packets
    a_last_closes_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && in_last_reg |=> byte_pos_reg == POS_IDLE)
        else $error("packet state not closed after last byte");

    // bytes of a skipped packet give no results
    a_skipped_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && !in_first_reg && packet_skipped_reg |=> slot_mask_reg == '0)
        else $error("skipped packet produced results");

    // a start code is always loaded whole, together with the nal header
    a_start_code_whole: assert property (@(posedge aclk) disable iff (!aresetn)
        consume |=> (slot_mask_reg[SLOT_ZERO_A] == slot_mask_reg[SLOT_ZERO_B])
                 && (slot_mask_reg[SLOT_ZERO_B] == slot_mask_reg[SLOT_ONE])
                 && (slot_mask_reg[SLOT_ONE] == slot_mask_reg[SLOT_HDR]))
        else $error("partial start code loaded");

    // a single nal packet never leaves a fragment run open
    a_single_no_frag: assert property (@(posedge aclk) disable iff (!aresetn)
        packet_kind_reg == KIND_SINGLE |-> !frag_open_reg)
        else $error("fragment run open inside single nal packet");

endmodule

`default_nettype wire

/* tb/vvcab_stream_checker.sv */
// checker for the vvc depacketizer: predicts the annex-b stream from payload transfers and compares
`timescale 1ns / 1ps

module vvcab_stream_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  vvcab_pkg::byte_t s_payload_byte,
    input  logic             s_first_of_packet,
    input  logic             s_last_of_packet,
    input  vvcab_pkg::seq_t  s_seq_number,
    input  logic             m_valid,
    input  logic             m_ready,
    input  vvcab_pkg::byte_t m_out_byte,
    input  logic             m_byte_valid,
    input  logic             m_end_of_nal,
    input  logic             m_nal_dropped,
    output int               pending_results,
    output int               fail_count
);
    import vvcab_pkg::*;

    typedef struct packed {
        byte_t data;
        logic  has_byte;
        logic  eon;
        logic  dropped;
    } annexb_word_t;

    annexb_word_t annexb_expected[$];

    // predicted depacketizer state
    seq_t        newest_seq;
    logic [15:0] pkt_pos;
    logic [1:0]  pkt_kind;
    logic        skip_rest;
    byte_t       hdr0;
    byte_t       hdr1;
    logic        run_open;
    logic        run_end_bit;
    unit_len_t   unit_left;
    logic [2:0]  agg_phase;

    task automatic push_word(input byte_t data, input logic has_byte, input logic eon,
                             input logic dropped);
        annexb_word_t w;
        w.data     = data;
        w.has_byte = has_byte;
        w.eon      = eon;
        w.dropped  = dropped;
        annexb_expected = {annexb_expected, w};
    endtask

    task automatic push_drop();
        push_word(8'h00, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic push_start_code(input logic [4:0] nal_type, input logic by_type);
        if (by_type && nal_type >= NAL_TYPE_LONG_LO && nal_type <= NAL_TYPE_LONG_HI)
            push_word(START_ZERO, 1'b1, 1'b0, 1'b0);
        push_word(START_ZERO, 1'b1, 1'b0, 1'b0);
        push_word(START_ZERO, 1'b1, 1'b0, 1'b0);
        push_word(START_ONE, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic clear_packet();
        pkt_pos     = '0;
        pkt_kind    = KIND_NONE;
        skip_rest   = 1'b0;
        run_end_bit = 1'b0;
        agg_phase   = PH_SIZE_HI;
        unit_left   = '0;
    endtask

    // a new packet while the previous one lacks its last byte
    task automatic close_cut_packet();
        if (pkt_pos != 0 && !skip_rest) begin
            case (pkt_kind)
                KIND_SINGLE: push_drop();
                KIND_AGGR: begin
                    if (agg_phase == PH_BODY)
                        push_drop();
                end
                KIND_FRAG: begin
                    if (run_open && run_end_bit) begin
                        push_drop();
                        run_open = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic step_unit(input byte_t b, input logic is_last);
        case (agg_phase)
            PH_SIZE_HI: begin
                unit_left = {b, 8'h00};
                agg_phase = PH_SIZE_LO;
            end
            PH_SIZE_LO: begin
                unit_left = unit_left | {8'h00, b};
                agg_phase = (unit_left == 0) ? PH_SIZE_HI : PH_HDR0;
            end
            PH_HDR0: begin
                hdr0      = b;
                unit_left = unit_left - 1'b1;
                agg_phase = (unit_left == 0) ? PH_SIZE_HI : PH_HDR1;
            end
            PH_HDR1: begin
                unit_left = unit_left - 1'b1;
                push_start_code(b[7:3], 1'b1);
                push_word(hdr0, 1'b1, 1'b0, 1'b0);
                push_word(b, 1'b1, unit_left == 0, 1'b0);
                agg_phase = (unit_left == 0) ? PH_SIZE_HI : PH_BODY;
            end
            default: begin
                unit_left = unit_left - 1'b1;
                push_word(b, 1'b1, unit_left == 0, 1'b0);
                if (unit_left == 0)
                    agg_phase = PH_SIZE_HI;
            end
        endcase
        if (is_last && agg_phase == PH_BODY)
            push_drop();
    endtask

    task automatic step_frag_header(input byte_t b, input logic is_last);
        if (b[7]) begin
            if (run_open)
                push_drop();
            push_start_code(5'd0, 1'b0);
            push_word(hdr0, 1'b1, 1'b0, 1'b0);
            push_word({b[4:0], hdr1[2:0]}, 1'b1, is_last && b[6], 1'b0);
            run_open    = !(is_last && b[6]);
            run_end_bit = b[6];
        end else if (run_open) begin
            run_end_bit = b[6];
            if (is_last && b[6]) begin
                push_word(8'h00, 1'b0, 1'b1, 1'b0);
                run_open = 1'b0;
            end
        end else begin
            skip_rest = 1'b1;
        end
    endtask

    task automatic predict_annexb(input byte_t b, input logic is_first, input logic is_last,
                                  input seq_t seq);
        logic [15:0] pos;
        if (is_first) begin
            close_cut_packet();
            clear_packet();
            if (seq < newest_seq)
                skip_rest = 1'b1;
            else
                newest_seq = seq;
        end
        if (is_first || pkt_pos != 0) begin
            pos = pkt_pos;
            if (pkt_pos != 16'hFFFF)
                pkt_pos = pkt_pos + 1'b1;
            if (!skip_rest) begin
                if (pos == 0) begin
                    hdr0 = b;
                end else if (pos == 1) begin
                    hdr1 = b;
                    if (b[7:3] == NAL_TYPE_FU) begin
                        pkt_kind = KIND_FRAG;
                    end else begin
                        pkt_kind = (b[7:3] == NAL_TYPE_AP) ? KIND_AGGR : KIND_SINGLE;
                        if (run_open) begin
                            push_drop();
                            run_open = 1'b0;
                        end
                        if (pkt_kind == KIND_SINGLE) begin
                            push_start_code(b[7:3], 1'b1);
                            push_word(hdr0, 1'b1, 1'b0, 1'b0);
                            push_word(b, 1'b1, is_last, 1'b0);
                        end
                    end
                end else if (pkt_kind == KIND_SINGLE) begin
                    push_word(b, 1'b1, is_last, 1'b0);
                end else if (pkt_kind == KIND_AGGR) begin
                    step_unit(b, is_last);
                end else if (pkt_kind == KIND_FRAG) begin
                    if (pos == 2) begin
                        step_frag_header(b, is_last);
                    end else if (run_open) begin
                        push_word(b, 1'b1, is_last && run_end_bit, 1'b0);
                        if (is_last && run_end_bit)
                            run_open = 1'b0;
                    end
                end
            end
            if (is_last)
                clear_packet();
        end
    endtask

    task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        fail_count++;
    endtask

    always @(posedge aclk) begin : track
        annexb_word_t want;
        if (!aresetn) begin
            newest_seq = '0;
            hdr0       = '0;
            hdr1       = '0;
            run_open   = 1'b0;
            clear_packet();
            annexb_expected.delete();
            fail_count = 0;
        end else begin
            // input first, so an item and its results keep their order
            if (s_valid && s_ready)
                predict_annexb(s_payload_byte, s_first_of_packet, s_last_of_packet,
                               s_seq_number);
            if (m_valid && m_ready) begin
                if (annexb_expected.size() == 0) begin
                    $error("result with none expected: out_byte 0x%0h", m_out_byte);
                    fail_count++;
                end else begin
                    want = annexb_expected.pop_front();
                    if (m_out_byte !== want.data)
                        flag_field("out_byte", want.data, m_out_byte);
                    if (m_byte_valid !== want.has_byte)
                        flag_field("byte_valid", {7'd0, want.has_byte}, {7'd0, m_byte_valid});
                    if (m_end_of_nal !== want.eon)
                        flag_field("end_of_nal", {7'd0, want.eon}, {7'd0, m_end_of_nal});
                    if (m_nal_dropped !== want.dropped)
                        flag_field("nal_dropped", {7'd0, want.dropped}, {7'd0, m_nal_dropped});
                end
            end
        end
        pending_results <= annexb_expected.size();
    end

endmodule

/* tb/tb_top.sv */
// top of the vvc depacketizer testbench: clock, reset, payload stimulus, sink stalls and verdict
`timescale 1ns / 1ps

module tb_top;
    import vvcab_pkg::*;

    // about this many payload bytes in the random part, ignored bytes not counted
    localparam int RANDOM_ITEMS = 320;
    // cycles to let the result register drain after the last expected result
    localparam int DRAIN_CYCLES = 30;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    byte_t s_payload_byte;
    logic  s_first_of_packet;
    logic  s_last_of_packet;
    seq_t  s_seq_number;
    logic  m_valid;
    logic  m_ready;
    byte_t m_out_byte;
    logic  m_byte_valid;
    logic  m_end_of_nal;
    logic  m_nal_dropped;

    int pending_results;
    int fail_count;

    // payload bytes of the packet being built
    byte_t pkt_bytes[$];
    int    items_counted;
    seq_t  next_seq;
    seq_t  newest_seq;
    // transfers left in a stretch with no idling, per side
    int    src_calm;
    int    sink_calm;

    vvc_rtp_to_annexb_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_payload_byte    (s_payload_byte),
        .s_first_of_packet (s_first_of_packet),
        .s_last_of_packet  (s_last_of_packet),
        .s_seq_number      (s_seq_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_byte_valid      (m_byte_valid),
        .m_end_of_nal      (m_end_of_nal),
        .m_nal_dropped     (m_nal_dropped)
    );

    vvcab_stream_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_payload_byte    (s_payload_byte),
        .s_first_of_packet (s_first_of_packet),
        .s_last_of_packet  (s_last_of_packet),
        .s_seq_number      (s_seq_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_byte_valid      (m_byte_valid),
        .m_end_of_nal      (m_end_of_nal),
        .m_nal_dropped     (m_nal_dropped),
        .pending_results   (pending_results),
        .fail_count        (fail_count)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // draws a random idle gap, or none inside a calm stretch
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm = $urandom_range(20, 60);
        return $urandom_range(0, 10);
    endfunction

    // result sink: stalls a random number of cycles before taking each result
    initial begin
        int stall;
        m_ready   = 1'b0;
        sink_calm = 0;
        forever begin
            @(negedge aclk);
            stall = draw_gap(sink_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            // hold ready until one result transfer has happened
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // one payload byte; called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input byte_t b, input logic is_first, input logic is_last,
                             input seq_t seq);
        int gap;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_payload_byte    <= b;
        s_first_of_packet <= is_first;
        s_last_of_packet  <= is_last;
        s_seq_number      <= seq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // sends pkt_bytes; without closed the last byte carries no end flag and the packet stays open
    task automatic send_packet(input seq_t seq, input logic closed);
        for (int i = 0; i < pkt_bytes.size(); i++)
            // sequence number only matters with the first byte, so junk rides on the rest
            send_byte(pkt_bytes[i], i == 0, closed && (i == pkt_bytes.size() - 1),
                      (i == 0) ? seq : seq_t'($urandom));
    endtask

    // next in-order sequence number, half of the steps small (0..2) and half jumps of up to 2000
    function automatic seq_t claim_seq();
        seq_t granted;
        int   step;
        granted    = next_seq;
        newest_seq = next_seq;
        step = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2000) : $urandom_range(0, 2);
        // 16'hffff is kept for the end of the run
        if (int'(next_seq) + step <= 65000)
            next_seq = next_seq + seq_t'(step);
        return granted;
    endfunction

    task automatic append_byte(input byte_t b);
        pkt_bytes = {pkt_bytes, b};
    endtask

    task automatic push_header(input logic [4:0] nal_type);
        pkt_bytes.delete();
        append_byte(byte_t'($urandom_range(0, 255)));
        append_byte({nal_type, 3'($urandom_range(0, 7))});
    endtask

    task automatic push_random(input int count);
        repeat (count) append_byte(byte_t'($urandom_range(0, 255)));
    endtask

    // single nal unit packet, at least a third of them with a type that takes the 4-byte start code
    task automatic build_single();
        logic [4:0] nal_type;
        if ($urandom_range(0, 2) == 0) begin
            nal_type = 5'($urandom_range(NAL_TYPE_LONG_LO, NAL_TYPE_LONG_HI));
        end else begin
            nal_type = 5'($urandom_range(0, 31));
            while (nal_type == NAL_TYPE_AP || nal_type == NAL_TYPE_FU)
                nal_type = 5'($urandom_range(0, 31));
        end
        push_header(nal_type);
        push_random(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6));
    endtask

    // aggregation packet: units of size 0, 1, small, or huge and cut; the final unit may be cut
    task automatic build_aggr();
        int n_units;
        int size;
        int kept;
        push_header(NAL_TYPE_AP);
        n_units = $urandom_range(1, 3);
        for (int u = 0; u < n_units; u++) begin
            case ($urandom_range(0, 19))
                0, 1:       size = 0;
                2, 3:       size = 1;
                4:          size = $urandom_range(256, 65535);
                5, 6, 7, 8: size = $urandom_range(7, 12);
                default:    size = $urandom_range(2, 6);
            endcase
            kept = size;
            if (size > 12)
                kept = $urandom_range(0, 10);
            else if (u == n_units - 1 && $urandom_range(0, 4) == 0)
                kept = $urandom_range(0, size);
            append_byte(byte_t'(size >> 8));
            append_byte(byte_t'(size));
            push_random(kept);
        end
    endtask

    // fragmentation packet with the given start and end bits
    task automatic build_frag(input logic s_bit, input logic e_bit, input int payload_len);
        push_header(NAL_TYPE_FU);
        append_byte({s_bit, e_bit, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31))});
        push_random(payload_len);
    endtask

    // in-order packet, a few left open so the next first byte truncates it
    task automatic send_counted();
        logic closed;
        closed = ($urandom_range(0, 99) >= 6);
        send_packet(claim_seq(), closed);
        items_counted += pkt_bytes.size();
    endtask

    // start, middles and end of one fragmented nal; some runs are abandoned before the end
    task automatic send_frag_run();
        int middles;
        if ($urandom_range(0, 9) == 0) begin
            build_frag(1'b1, 1'b1, $urandom_range(0, 5));
            send_counted();
        end else begin
            middles = $urandom_range(0, 2);
            build_frag(1'b1, 1'b0, $urandom_range(0, 5));
            send_counted();
            repeat (middles) begin
                build_frag(1'b0, 1'b0, $urandom_range(0, 5));
                send_counted();
            end
            // end fragment, payload may be empty
            if ($urandom_range(0, 99) >= 15) begin
                build_frag(1'b0, 1'b1, $urandom_range(0, 5));
                send_counted();
            end
        end
    endtask

    // broken or ignored traffic
    task automatic send_noise();
        case ($urandom_range(0, 5))
            0: begin
                // one-byte packet
                pkt_bytes.delete();
                push_random(1);
                send_packet(claim_seq(), 1'b1);
            end
            1: begin
                // fragmentation packet with no fu header
                push_header(NAL_TYPE_FU);
                send_packet(claim_seq(), 1'b1);
            end
            2: begin
                // non-start fragment, orphan unless a run is still open
                build_frag(1'b0, 1'($urandom_range(0, 1)), $urandom_range(0, 4));
                send_counted();
            end
            3: begin
                // late packet
                if (newest_seq > 0) begin
                    build_single();
                    send_packet(seq_t'($urandom_range(0, newest_seq - 1)), 1'b1);
                end
            end
            4: begin
                // stray bytes with no first flag
                repeat ($urandom_range(1, 3))
                    send_byte(byte_t'($urandom_range(0, 255)), 1'b0,
                              1'($urandom_range(0, 1)), seq_t'($urandom));
            end
            default: begin
                // random content after a random header byte pair
                pkt_bytes.delete();
                push_random($urandom_range(2, 8));
                send_counted();
            end
        endcase
    endtask

    initial begin
        int choice;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_payload_byte    = '0;
        s_first_of_packet = 1'b0;
        s_last_of_packet  = 1'b0;
        s_seq_number      = '0;
        items_counted     = 0;
        next_seq          = 16'd8;
        newest_seq        = 16'd7;
        src_calm          = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part
        // two-byte single nal, type 0, all-zero bytes and sequence 0
        pkt_bytes = '{8'h00, 8'h00};
        send_packet(16'd0, 1'b1);
        // type 13 takes the 4-byte start code
        pkt_bytes = '{8'hFF, 8'h6F};
        send_packet(16'd1, 1'b1);
        // one-byte packet is ignored
        pkt_bytes = '{8'h34};
        send_packet(16'd1, 1'b1);
        // byte with no packet open
        send_byte(8'h55, 1'b0, 1'b0, 16'hFFFF);
        // aggregation: a type 18 unit, then a unit cut by the packet end
        pkt_bytes = '{8'h80, 8'hE7, 8'h00, 8'h03, 8'h01, 8'h90, 8'hAB,
                      8'h00, 8'h09, 8'hC3, 8'hA0, 8'h5A};
        send_packet(16'd5, 1'b1);
        // late packet
        pkt_bytes = '{8'h00, 8'h08};
        send_packet(16'd4, 1'b1);
        // start fragment left open, then a start-and-end fragment interrupts the run
        pkt_bytes = '{8'h00, 8'hE8, 8'h85, 8'h11};
        send_packet(16'd6, 1'b0);
        pkt_bytes = '{8'h00, 8'hEB, 8'hDF, 8'h22};
        send_packet(16'd7, 1'b1);

        // random part, mostly well-formed packets with random content
        while (items_counted < RANDOM_ITEMS) begin
            choice = $urandom_range(0, 99);
            if (choice < 30) begin
                build_single();
                send_counted();
            end else if (choice < 55) begin
                build_aggr();
                send_counted();
            end else if (choice < 85) begin
                send_frag_run();
            end else begin
                send_noise();
            end
        end

        // highest sequence number, then a late packet behind it
        build_single();
        send_packet(16'hFFFF, 1'b1);
        build_single();
        send_packet(seq_t'($urandom_range(0, 16'hFFFE)), 1'b1);
        s_valid <= 1'b0;

        while (pending_results != 0) @(posedge aclk);
        // catch any extra result still leaving the result register
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
